// ===== src/cfr_pkg.sv =====
// Package for the CAN fragment reassembler: buffer sizing, word types,
// outcome codes and configuration register indexes. No dependencies.
`default_nettype none

package cfr_pkg;

    localparam int BUFFER_BYTES = 1024;
    localparam int ADDR_W       = $clog2(BUFFER_BYTES);
    localparam int LEN_W        = $clog2(BUFFER_BYTES + 1);
    localparam int OFS_W        = 17;
    localparam int CODE_W       = 21;
    localparam int CFG_IDX_W    = 3;

    localparam logic [OFS_W-1:0] BUF_END = OFS_W'(BUFFER_BYTES);

    localparam logic [7:0] NODE_BROADCAST = 8'hFF;

    localparam logic [2:0] OUT_IGNORED   = 3'd0;
    localparam logic [2:0] OUT_STORED    = 3'd1;
    localparam logic [2:0] OUT_OFS_RANGE = 3'd2;
    localparam logic [2:0] OUT_CRC_OK    = 3'd3;
    localparam logic [2:0] OUT_CRC_BAD   = 3'd4;
    localparam logic [2:0] OUT_LEN_BIG   = 3'd5;
    localparam logic [2:0] OUT_SHORT     = 3'd6;
    localparam logic [2:0] OUT_READ      = 3'd7;

    localparam logic [CFG_IDX_W-1:0] REG_OWN_ID     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_SHORT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_LONG  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PROC_LONG  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PROC_SHORT = 3'd4;

    typedef struct packed {
        logic        command;
        logic        is_extended;
        logic [28:0] frame_id;
        logic [3:0]  frame_length;
        logic [63:0] payload;
        logic [9:0]  read_index;
    } cfr_in_t;

    typedef struct packed {
        logic [2:0]  outcome;
        logic [7:0]  sender_id;
        logic        send_flag;
        logic [10:0] packet_length;
        logic [47:0] short_payload;
        logic [7:0]  read_byte;
    } cfr_out_t;

    typedef struct packed {
        logic [7:0]        own_id;
        logic [CODE_W-1:0] code_fill_short;
        logic [CODE_W-1:0] code_fill_long;
        logic [CODE_W-1:0] code_process_long;
        logic [CODE_W-1:0] code_process_short;
    } cfr_cfg_t;

endpackage

`default_nettype wire

// ===== src/cfr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module cfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/cfr_engine.sv =====
// Frame sequencer: decodes a word, runs fill, read and CRC walks against the
// packet buffer RAM, and holds the result. Depends on cfr_pkg and cfr_ram.
`default_nettype none

module cfr_engine
    import cfr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cfr_cfg_t cfg,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire cfr_in_t  in_data,
    output logic          res_valid,
    input  wire logic     res_ready,
    output cfr_out_t      res_data
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_FILL   = 3'd2;
    localparam logic [2:0] ST_RDWAIT = 3'd3;
    localparam logic [2:0] ST_CRC    = 3'd4;
    localparam logic [2:0] ST_RESULT = 3'd5;

    function automatic logic [7:0] byte_at(input logic [63:0] pl, input logic [2:0] k);
        byte_at = pl[{k, 3'b000} +: 8];
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] d);
        logic [15:0] c;
        c = crc_in ^ {d, 8'h00};
        for (int b = 0; b < 8; b++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
        end
        crc_byte = c;
    endfunction

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [7:0]        sender_reg, sender_next;
    logic              flag_reg, flag_next;

    logic [63:0]       pl_reg, pl_next;
    logic [3:0]        dlc_reg, dlc_next;
    logic [3:0]        kidx_reg, kidx_next;
    logic [OFS_W-1:0]  waddr_reg, waddr_next;
    logic              rdok_reg, rdok_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    logic              pend_reg, pend_next;
    logic [15:0]       crc_reg, crc_next;
    logic [15:0]       want_reg, want_next;
    logic [2:0]        outc_reg, outc_next;
    logic [10:0]       plen_reg, plen_next;
    logic [47:0]       spay_reg, spay_next;
    logic [7:0]        rbyte_reg, rbyte_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]        ram_wdata, ram_rdata;

    // decode of the incoming word
    logic [3:0]        dlc_in;
    logic [7:0]        node_in;
    logic [CODE_W-1:0] code_in;
    logic              node_ok;
    logic [OFS_W-1:0]  ofs_long, ridx_ext, len_ext16, len_q_ext;
    logic [3:0]        nshort;
    logic [47:0]       spay_in;
    logic              accept;

    cfr_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign res_valid = (state_reg == ST_RESULT);

    assign dlc_in    = (in_data.frame_length > 4'd8) ? 4'd8 : in_data.frame_length;
    assign node_in   = in_data.frame_id[7:0];
    assign code_in   = in_data.frame_id[28:8];
    assign node_ok   = (node_in == NODE_BROADCAST) || (node_in == cfg.own_id);
    assign ofs_long  = OFS_W'({byte_at(in_data.payload, 3'd0), byte_at(in_data.payload, 3'd1)});
    assign len_ext16 = OFS_W'({byte_at(in_data.payload, 3'd2), byte_at(in_data.payload, 3'd3)});
    assign ridx_ext  = OFS_W'(in_data.read_index);
    assign len_q_ext = OFS_W'(len_reg);
    assign nshort    = (dlc_in >= 4'd2) ? (dlc_in - 4'd2) : 4'd0;

    always_comb
    begin
        spay_in = '0;
        for (int k = 0; k < 6; k++)
        begin
            if (4'(k) < nshort)
            begin
                spay_in[8*k +: 8] = byte_at(in_data.payload, 3'(k + 2));
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        sender_next = sender_reg;
        flag_next   = flag_reg;
        pl_next     = pl_reg;
        dlc_next    = dlc_reg;
        kidx_next   = kidx_reg;
        waddr_next  = waddr_reg;
        rdok_next   = rdok_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        pend_next   = 1'b0;
        crc_next    = crc_reg;
        want_next   = want_reg;
        outc_next   = outc_reg;
        plen_next   = plen_reg;
        spay_next   = spay_reg;
        rbyte_next  = rbyte_reg;

        ram_we    = 1'b0;
        ram_waddr = waddr_reg[ADDR_W-1:0];
        ram_wdata = byte_at(pl_reg, kidx_reg[2:0]);
        ram_raddr = ridx_ext[ADDR_W-1:0];

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = 8'h00;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(BUFFER_BYTES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    pl_next    = in_data.payload;
                    dlc_next   = dlc_in;
                    outc_next  = OUT_IGNORED;
                    plen_next  = '0;
                    spay_next  = '0;
                    rbyte_next = '0;
                    state_next = ST_RESULT;
                    if (in_data.command)
                    begin
                        // read issued now, data lands next cycle
                        rdok_next  = (ridx_ext < BUF_END);
                        state_next = ST_RDWAIT;
                    end
                    else if (in_data.is_extended && node_ok)
                    begin
                        if (code_in == cfg.code_fill_short)
                        begin
                            kidx_next  = 4'd1;
                            waddr_next = OFS_W'(byte_at(in_data.payload, 3'd0));
                            state_next = ST_FILL;
                        end
                        else if (code_in == cfg.code_fill_long)
                        begin
                            if (ofs_long < BUF_END)
                            begin
                                kidx_next  = 4'd2;
                                waddr_next = ofs_long;
                                state_next = ST_FILL;
                            end
                            else
                            begin
                                outc_next = OUT_OFS_RANGE;
                            end
                        end
                        else if (code_in == cfg.code_process_long)
                        begin
                            sender_next = byte_at(in_data.payload, 3'd0);
                            flag_next   = (byte_at(in_data.payload, 3'd1) != 8'h00);
                            if (len_ext16 > BUF_END)
                            begin
                                outc_next = OUT_LEN_BIG;
                            end
                            else
                            begin
                                len_next   = len_ext16[LEN_W-1:0];
                                want_next  = {byte_at(in_data.payload, 3'd4),
                                              byte_at(in_data.payload, 3'd5)};
                                cnt_next   = '0;
                                crc_next   = '0;
                                state_next = ST_CRC;
                            end
                        end
                        else if (code_in == cfg.code_process_short)
                        begin
                            sender_next = byte_at(in_data.payload, 3'd0);
                            flag_next   = (byte_at(in_data.payload, 3'd1) != 8'h00);
                            outc_next   = OUT_SHORT;
                            plen_next   = 11'(nshort);
                            spay_next   = spay_in;
                        end
                    end
                end
            end

            ST_FILL:
            begin
                if (kidx_reg < dlc_reg)
                begin
                    // drop bytes that fall past the buffer end
                    ram_we     = (waddr_reg < BUF_END);
                    kidx_next  = kidx_reg + 4'd1;
                    waddr_next = waddr_reg + 1'b1;
                end
                else
                begin
                    outc_next  = OUT_STORED;
                    state_next = ST_RESULT;
                end
            end

            ST_RDWAIT:
            begin
                outc_next  = OUT_READ;
                rbyte_next = rdok_reg ? ram_rdata : 8'h00;
                state_next = ST_RESULT;
            end

            ST_CRC:
            begin
                ram_raddr = OFS_W'(cnt_reg) < BUF_END ? cnt_reg[ADDR_W-1:0] : '0;
                if (cnt_reg < len_reg)
                begin
                    pend_next = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    crc_next = crc_byte(crc_reg, ram_rdata);
                end
                if (!(cnt_reg < len_reg) && !pend_reg)
                begin
                    outc_next  = (crc_reg == want_reg) ? OUT_CRC_OK : OUT_CRC_BAD;
                    plen_next  = len_q_ext[10:0];
                    state_next = ST_RESULT;
                end
            end

            ST_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            sender_reg <= '0;
            flag_reg   <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            sender_reg <= sender_next;
            flag_reg   <= flag_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pl_reg    <= pl_next;
        dlc_reg   <= dlc_next;
        kidx_reg  <= kidx_next;
        waddr_reg <= waddr_next;
        rdok_reg  <= rdok_next;
        len_reg   <= len_next;
        cnt_reg   <= cnt_next;
        crc_reg   <= crc_next;
        want_reg  <= want_next;
        outc_reg  <= outc_next;
        plen_reg  <= plen_next;
        spay_reg  <= spay_next;
        rbyte_reg <= rbyte_next;
    end

    always_comb
    begin
        res_data.outcome       = outc_reg;
        res_data.sender_id     = sender_reg;
        res_data.send_flag     = flag_reg;
        res_data.packet_length = plen_reg;
        res_data.short_payload = spay_reg;
        res_data.read_byte     = rbyte_reg;
    end

endmodule

`default_nettype wire

// ===== src/can_fragment_reassembler_top.sv =====
// Top level of the CAN fragment reassembler: configuration registers, the
// output register and the frame sequencer. Depends on cfr_pkg and cfr_engine.
//
//  channel | signals                       | moves
//  --------+-------------------------------+--------------------------------
//  in      | in_valid, in_ready, in_data   | one frame or read-command word
//  out     | out_valid, out_ready, out_data| one result word per input word
//  cfg     | cfg_we, cfg_index, cfg_data   | register write, no wait
//
// Work per word: an ignored word, a short packet, an out-of-range offset or an
// oversize length goes straight to the result; a read waits for the RAM data; a
// fill writes its payload bytes through the single RAM write port; a CRC check
// walks the buffer one byte per cycle through the RAM read port.
// After reset a clearing pass writes zero to every buffer byte, during which
// in_ready stays low; configuration writes still land.
// The output register lets the next word be taken while a result waits.
`default_nettype none

module can_fragment_reassembler_top
    import cfr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire cfr_in_t              in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output cfr_out_t                  out_data,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CODE_W-1:0]    cfg_data
);

    cfr_cfg_t cfg_reg;
    logic     out_valid_reg;
    cfr_out_t out_data_reg;
    logic     res_valid, res_ready;
    cfr_out_t res_data;

    // configuration registers; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_id             <= 8'd0;
            cfg_reg.code_fill_short    <= CODE_W'(5);
            cfg_reg.code_fill_long     <= CODE_W'(6);
            cfg_reg.code_process_long  <= CODE_W'(7);
            cfg_reg.code_process_short <= CODE_W'(8);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OWN_ID:     cfg_reg.own_id             <= cfg_data[7:0];
                REG_FILL_SHORT: cfg_reg.code_fill_short    <= cfg_data;
                REG_FILL_LONG:  cfg_reg.code_fill_long     <= cfg_data;
                REG_PROC_LONG:  cfg_reg.code_process_long  <= cfg_data;
                REG_PROC_SHORT: cfg_reg.code_process_short <= cfg_data;
                default:        ;
            endcase
        end
    end

    cfr_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    // hold the result until taken; load a fresh one as the old one leaves
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= res_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire
